FILE: hdl/mti_pulse_canceller_defines.svh
// assertion macros shared by the pulse canceller modules
`ifndef MTI_PULSE_CANCELLER_DEFINES_SVH
`define MTI_PULSE_CANCELLER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge out of reset
`define MTIPC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("%m: check failed");

// condition must never be seen at a clock edge out of reset
`define MTIPC_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define MTIPC_ASSERT(lbl, clk, rstn, prop)
`define MTIPC_NEVER(lbl, clk, rstn, cond)

`endif

`endif

FILE: hdl/mtipc_pkg.sv
// shared types, constants and helpers of the pulse canceller
`default_nettype none

package mtipc_pkg;

  localparam int MAX_BINS    = 4096;
  localparam int BIN_W       = $clog2(MAX_BINS);
  localparam int MAX_PULSES  = 256;
  localparam int PULSE_W     = $clog2(MAX_PULSES);
  localparam int SAMPLE_BITS = 16;
  localparam int OUT_W       = SAMPLE_BITS + 2;
  localparam int SPP_W       = 13;
  localparam int PPD_W       = 9;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 13;
  localparam int OBUF_DEPTH  = 4;
  localparam int OBUF_PTR_W  = $clog2(OBUF_DEPTH);
  localparam int OBUF_CNT_W  = OBUF_PTR_W + 1;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE = 2'd0,
    CFG_SPP  = 2'd1,
    CFG_PPD  = 2'd2
  } cfg_reg_e;

  typedef enum logic {
    MODE_TWO_PULSE   = 1'b0,
    MODE_THREE_PULSE = 1'b1
  } mode_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] re;
    logic signed [SAMPLE_BITS-1:0] im;
  } sample_t;

  // one delay line entry: previous pulse and the pulse before it
  typedef struct packed {
    sample_t one;
    sample_t two;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  // per-item control from the sequencer
  typedef struct packed {
    logic [BIN_W-1:0] addr;
    logic             emit;
    logic             last;
  } item_ctl_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
    logic                    last;
  } result_t;

  function automatic logic signed [OUT_W-1:0] sext_out(input logic signed [SAMPLE_BITS-1:0] v);
    sext_out = {{(OUT_W - SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/mtipc_channels.sv
// valid/ready channel interfaces for samples and canceller results
`default_nettype none

interface mtipc_in_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [mtipc_pkg::SAMPLE_BITS-1:0] in_real;
  logic signed [mtipc_pkg::SAMPLE_BITS-1:0] in_imag;

  modport source (output valid, output in_real, output in_imag, input ready);
  modport sink (input valid, input in_real, input in_imag, output ready);
endinterface

interface mtipc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [mtipc_pkg::OUT_W-1:0] out_real;
  logic signed [mtipc_pkg::OUT_W-1:0] out_imag;
  logic                               dwell_last;

  modport source (output valid, output out_real, output out_imag, output dwell_last,
                  input ready);
  modport sink (input valid, input out_real, input out_imag, input dwell_last,
                output ready);
endinterface

`default_nettype wire

FILE: hdl/mtipc_ram.sv
// generic single-port-write, single-port-read ram with registered read
`default_nettype none

module mtipc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mtipc_seq.sv
// configuration registers and bin/pulse sequencing of the canceller
`default_nettype none

`include "mti_pulse_canceller_defines.svh"

module mtipc_seq (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [mtipc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mtipc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  wire logic                                accept_i,
  output mtipc_pkg::mode_e                         mode_o,
  output mtipc_pkg::item_ctl_t                     ctl_o
);

  mtipc_pkg::mode_e                     mode_q;
  logic [mtipc_pkg::SPP_W-1:0]          spp_q;
  logic [mtipc_pkg::PPD_W-1:0]          ppd_q;
  logic [mtipc_pkg::BIN_W-1:0]          bin_q, bin_d;
  logic [mtipc_pkg::PULSE_W-1:0]        pulse_q, pulse_d;
  logic [mtipc_pkg::BIN_W-1:0]          last_bin;
  logic [mtipc_pkg::PULSE_W-1:0]        last_pulse;
  logic [mtipc_pkg::PULSE_W-1:0]        first_pulse;
  logic                                 bin_wrap;
  logic                                 pulse_wrap;

  // clamp the bin count to 1..MAX_BINS, kept as the index of the last bin
  always_comb begin
    if (spp_q == '0) begin
      last_bin = '0;
    end else if (spp_q >= mtipc_pkg::SPP_W'(mtipc_pkg::MAX_BINS)) begin
      last_bin = mtipc_pkg::BIN_W'(mtipc_pkg::MAX_BINS - 1);
    end else begin
      last_bin = mtipc_pkg::BIN_W'(spp_q - 1'b1);
    end
  end

  // clamp the pulse count to 2..MAX_PULSES
  always_comb begin
    if (ppd_q < mtipc_pkg::PPD_W'(2)) begin
      last_pulse = mtipc_pkg::PULSE_W'(1);
    end else if (ppd_q >= mtipc_pkg::PPD_W'(mtipc_pkg::MAX_PULSES)) begin
      last_pulse = mtipc_pkg::PULSE_W'(mtipc_pkg::MAX_PULSES - 1);
    end else begin
      last_pulse = mtipc_pkg::PULSE_W'(ppd_q - 1'b1);
    end
  end

  assign first_pulse = (mode_q == mtipc_pkg::MODE_THREE_PULSE) ? mtipc_pkg::PULSE_W'(2)
                                                                : mtipc_pkg::PULSE_W'(1);
  assign bin_wrap    = (bin_q >= last_bin);
  assign pulse_wrap  = (pulse_q >= last_pulse);

  // control for the item offered this cycle
  assign ctl_o.addr = bin_q;
  assign ctl_o.emit = (pulse_q >= first_pulse);
  assign ctl_o.last = (pulse_q == last_pulse) && (bin_q == last_bin);
  assign mode_o     = mode_q;

  // counter advance
  always_comb begin
    bin_d   = bin_q;
    pulse_d = pulse_q;
    if (cfg_we_i) begin
      bin_d   = '0;
      pulse_d = '0;
    end else if (accept_i) begin
      if (bin_wrap) begin
        bin_d   = '0;
        pulse_d = pulse_wrap ? '0 : pulse_q + 1'b1;
      end else begin
        bin_d = bin_q + 1'b1;
      end
    end
  end

  // registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= mtipc_pkg::MODE_TWO_PULSE;
      spp_q   <= mtipc_pkg::SPP_W'(1000);
      ppd_q   <= mtipc_pkg::PPD_W'(32);
      bin_q   <= '0;
      pulse_q <= '0;
    end else begin
      bin_q   <= bin_d;
      pulse_q <= pulse_d;
      if (cfg_we_i) begin
        unique case (mtipc_pkg::cfg_reg_e'(cfg_idx_i))
          mtipc_pkg::CFG_MODE: mode_q <= mtipc_pkg::mode_e'(cfg_data_i[0]);
          mtipc_pkg::CFG_SPP:  spp_q  <= cfg_data_i[mtipc_pkg::SPP_W-1:0];
          mtipc_pkg::CFG_PPD:  ppd_q  <= cfg_data_i[mtipc_pkg::PPD_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // counters stay inside the current dwell geometry
  `MTIPC_ASSERT(a_bin_in_range, clk_i, rst_ni, bin_q <= last_bin)
  `MTIPC_ASSERT(a_pulse_in_range, clk_i, rst_ni, pulse_q <= last_pulse)

endmodule

`default_nettype wire

FILE: hdl/mtipc_fifo.sv
// small result buffer that decouples the canceller from the output channel
`default_nettype none

`include "mti_pulse_canceller_defines.svh"

module mtipc_fifo (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              push_i,
  input  wire mtipc_pkg::result_t                push_data_i,
  output logic [mtipc_pkg::OBUF_CNT_W-1:0]       count_o,
  mtipc_out_if.source                            out_result
);

  mtipc_pkg::result_t                    buf_q [mtipc_pkg::OBUF_DEPTH];
  logic [mtipc_pkg::OBUF_PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [mtipc_pkg::OBUF_CNT_W-1:0]      count_q;
  logic                                  pop;
  mtipc_pkg::result_t                    head;

  assign pop     = out_result.valid && out_result.ready;
  assign head    = buf_q[rd_ptr_q];
  assign count_o = count_q;

  // output channel from the head entry
  assign out_result.valid      = (count_q != '0);
  assign out_result.out_real   = head.re;
  assign out_result.out_imag   = head.im;
  assign out_result.dwell_last = head.last;

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + mtipc_pkg::OBUF_CNT_W'(push_i) - mtipc_pkg::OBUF_CNT_W'(pop);
    end
  end

  // buffer never overflows and the level tracks the pointers
  `MTIPC_NEVER(a_no_overflow, clk_i, rst_ni,
               push_i && !pop && (count_q == mtipc_pkg::OBUF_CNT_W'(mtipc_pkg::OBUF_DEPTH)))
  `MTIPC_ASSERT(a_level_matches, clk_i, rst_ni,
                count_q[mtipc_pkg::OBUF_PTR_W-1:0] == (wr_ptr_q - rd_ptr_q))

endmodule

`default_nettype wire

FILE: hdl/mti_pulse_canceller.sv
// top level of the two/three pulse mti canceller
//
//  channel     dir  handshake     payload
//  in_sample   in   valid/ready   in_real[15:0], in_imag[15:0] signed
//  out_result  out  valid/ready   out_real[17:0], out_imag[17:0] signed, dwell_last
//  cfg         in   cfg_we_i      cfg_idx_i[1:0], cfg_data_i[12:0]
//
// one sample per clock sustained; results pass the stage and the result buffer.
// the rate is set by the delay line ram: one read and one write of a bin per cycle,
// with a forward path when the same bin is hit on consecutive cycles.
// no clearing pass after reset: delay lines are written before a result uses them.
// the input stalls once the four-entry result buffer has no room left beside the
// request in flight.
`default_nettype none

`include "mti_pulse_canceller_defines.svh"

module mti_pulse_canceller (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  mtipc_in_if.sink                               in_sample,
  mtipc_out_if.source                            out_result,
  input  wire logic                              cfg_we_i,
  input  wire logic [mtipc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mtipc_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  logic                                  accept;
  mtipc_pkg::mode_e                      mode;
  mtipc_pkg::item_ctl_t                  ctl;
  logic [mtipc_pkg::OBUF_CNT_W-1:0]      obuf_count;
  logic [mtipc_pkg::LINE_W-1:0]          rd_raw;
  mtipc_pkg::line_t                      rd_line;

  // compute stage registers
  logic                                  s1_valid_q;
  mtipc_pkg::item_ctl_t                  s1_ctl_q;
  mtipc_pkg::mode_e                      s1_mode_q;
  mtipc_pkg::sample_t                    s1_x_q;
  logic                                  fwd_q;
  mtipc_pkg::line_t                      fwd_line_q;

  mtipc_pkg::sample_t                    one_eff, two_eff;
  mtipc_pkg::line_t                      wr_line;
  mtipc_pkg::result_t                    res;
  logic                                  push;

  // input side: room for everything in flight
  assign in_sample.ready = ({1'b0, obuf_count} + mtipc_pkg::OBUF_CNT_W'(s1_valid_q))
                           < (mtipc_pkg::OBUF_CNT_W + 1)'(mtipc_pkg::OBUF_DEPTH);
  assign accept = in_sample.valid && in_sample.ready;

  mtipc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .mode_o     (mode),
    .ctl_o      (ctl)
  );

  // delay lines: previous and second previous pulse per bin
  mtipc_ram #(
    .WIDTH (mtipc_pkg::LINE_W),
    .DEPTH (mtipc_pkg::MAX_BINS)
  ) u_delay_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_ctl_q.addr),
    .wdata_i (wr_line),
    .re_i    (accept),
    .raddr_i (ctl.addr),
    .rdata_o (rd_raw)
  );

  assign rd_line = rd_raw;

  // stage registers; forward when the bin just written is read again
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      fwd_q      <= accept && s1_valid_q && (s1_ctl_q.addr == ctl.addr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_ctl_q   <= ctl;
      s1_mode_q  <= mode;
      s1_x_q.re  <= in_sample.in_real;
      s1_x_q.im  <= in_sample.in_imag;
      fwd_line_q <= wr_line;
    end
  end

  // delay taps and write-back
  assign one_eff     = fwd_q ? fwd_line_q.one : rd_line.one;
  assign two_eff     = fwd_q ? fwd_line_q.two : rd_line.two;
  assign wr_line.one = s1_x_q;
  assign wr_line.two = one_eff;

  // canceller arithmetic
  always_comb begin
    res.last = s1_ctl_q.last;
    if (s1_mode_q == mtipc_pkg::MODE_THREE_PULSE) begin
      res.re = mtipc_pkg::sext_out(s1_x_q.re)
             - {one_eff.re[mtipc_pkg::SAMPLE_BITS-1], one_eff.re, 1'b0}
             + mtipc_pkg::sext_out(two_eff.re);
      res.im = mtipc_pkg::sext_out(s1_x_q.im)
             - {one_eff.im[mtipc_pkg::SAMPLE_BITS-1], one_eff.im, 1'b0}
             + mtipc_pkg::sext_out(two_eff.im);
    end else begin
      res.re = mtipc_pkg::sext_out(s1_x_q.re) - mtipc_pkg::sext_out(one_eff.re);
      res.im = mtipc_pkg::sext_out(s1_x_q.im) - mtipc_pkg::sext_out(one_eff.im);
    end
  end

  assign push = s1_valid_q && s1_ctl_q.emit;

  mtipc_fifo u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .count_o     (obuf_count),
    .out_result  (out_result)
  );

  // forwarding only follows an item written in the cycle before
  `MTIPC_ASSERT(a_fwd_follows_write, clk_i, rst_ni, fwd_q |-> (s1_valid_q && $past(s1_valid_q)))

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// self-checking testbench of the two/three pulse mti canceller
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mtipc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned RANDOM_ITEMS  = 260;
  localparam int unsigned LIMIT_NS      = 100_000_000;

  // index past the register list, only clears the counters
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  mtipc_in_if  sample_if ();
  mtipc_out_if result_if ();

  mti_pulse_canceller u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_sample  (sample_if),
    .out_result (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // samples waiting to be driven and residues waiting to come out
  sample_t     samples_to_send[$];
  result_t     predicted_residues[$];
  int unsigned samples_queued   = 0;
  int unsigned samples_accepted = 0;
  int unsigned mismatch_count   = 0;

  bit          sample_taken = 1'b0;
  bit          send_idle_on = 1'b1;
  bit          recv_idle_on = 1'b1;
  int unsigned send_gap     = 0;
  int unsigned recv_stall   = 0;
  sample_t     drive_smp;
  result_t     want;

  // canceller state as the block should hold it
  mode_e            cur_mode  = MODE_TWO_PULSE;
  logic [SPP_W-1:0] cur_spp   = SPP_W'(1000);
  logic [PPD_W-1:0] cur_ppd   = PPD_W'(32);
  sample_t          line_one [MAX_BINS];
  sample_t          line_two [MAX_BINS];
  int unsigned      bin_pos   = 0;
  int unsigned      pulse_pos = 0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_bins(input logic [SPP_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_BINS) return MAX_BINS;
    return 32'(v);
  endfunction

  function automatic int unsigned eff_pulses(input logic [PPD_W-1:0] v);
    if (v < 2) return 2;
    if (v > MAX_PULSES) return MAX_PULSES;
    return 32'(v);
  endfunction

  // idle length: mostly none, some short, a few long
  function automatic int unsigned pick_idle(input bit enabled);
    int unsigned roll;
    if (!enabled) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 94) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_value();
    case ($urandom_range(15))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // residue of one sample against the previous one or two pulses
  function automatic void cancel_clutter(input logic signed [SAMPLE_BITS-1:0] re,
                                         input logic signed [SAMPLE_BITS-1:0] im);
    int unsigned nb;
    int unsigned np;
    int unsigned first;
    int          re_acc;
    int          im_acc;
    result_t     r;
    nb    = eff_bins(cur_spp);
    np    = eff_pulses(cur_ppd);
    first = (cur_mode == MODE_THREE_PULSE) ? 2 : 1;
    if (pulse_pos >= first) begin
      if (first == 2) begin
        re_acc = int'(re) - 2 * int'(line_one[bin_pos].re) + int'(line_two[bin_pos].re);
        im_acc = int'(im) - 2 * int'(line_one[bin_pos].im) + int'(line_two[bin_pos].im);
      end else begin
        re_acc = int'(re) - int'(line_one[bin_pos].re);
        im_acc = int'(im) - int'(line_one[bin_pos].im);
      end
      r.re   = re_acc[OUT_W-1:0];
      r.im   = im_acc[OUT_W-1:0];
      r.last = (pulse_pos + 1 == np) && (bin_pos + 1 == nb);
      predicted_residues = {predicted_residues, r};
    end
    line_two[bin_pos]    = line_one[bin_pos];
    line_one[bin_pos].re = re;
    line_one[bin_pos].im = im;
    // step through bins, then pulses, then wrap at the end of the dwell
    if (bin_pos + 1 >= nb) begin
      bin_pos   = 0;
      pulse_pos = (pulse_pos + 1 >= np) ? 0 : pulse_pos + 1;
    end else begin
      bin_pos = bin_pos + 1;
    end
  endfunction

  // sample driver: holds a request until it is taken
  always @(negedge clk_i) begin
    if (!sample_if.valid || sample_taken) begin
      if (send_gap != 0 || samples_to_send.size() == 0) begin
        sample_if.valid <= 1'b0;
        if (send_gap != 0) send_gap--;
      end else begin
        drive_smp = samples_to_send.pop_front();
        sample_if.valid   <= 1'b1;
        sample_if.in_real <= drive_smp.re;
        sample_if.in_imag <= drive_smp.im;
        send_gap = pick_idle(send_idle_on);
      end
    end
  end

  // result sink: random back pressure
  always @(negedge clk_i) begin
    if (recv_stall != 0) begin
      result_if.ready <= 1'b0;
      recv_stall--;
    end else begin
      result_if.ready <= 1'b1;
      recv_stall = pick_idle(recv_idle_on);
    end
  end

  // monitor: register writes, accepted samples and results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MODE: cur_mode = mode_e'(cfg_data[0]);
          CFG_SPP:  cur_spp  = cfg_data[SPP_W-1:0];
          CFG_PPD:  cur_ppd  = cfg_data[PPD_W-1:0];
          default: ;
        endcase
        bin_pos   = 0;
        pulse_pos = 0;
      end
      sample_taken = sample_if.valid && sample_if.ready;
      if (sample_taken) begin
        cancel_clutter(sample_if.in_real, sample_if.in_imag);
        samples_accepted++;
      end
      if (result_if.valid && result_if.ready) begin
        if (predicted_residues.size() == 0) begin
          report_mismatch($sformatf("unexpected result re=%0d im=%0d last=%0b",
                                    result_if.out_real, result_if.out_imag,
                                    result_if.dwell_last));
        end else begin
          want = predicted_residues.pop_front();
          if (result_if.out_real !== want.re)
            report_mismatch($sformatf("out_real %0d, want %0d", result_if.out_real, want.re));
          if (result_if.out_imag !== want.im)
            report_mismatch($sformatf("out_imag %0d, want %0d", result_if.out_imag, want.im));
          if (result_if.dwell_last !== want.last)
            report_mismatch($sformatf("dwell_last %0b, want %0b", result_if.dwell_last,
                                      want.last));
        end
      end
    end
  end

  task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] re,
                              input logic signed [SAMPLE_BITS-1:0] im);
    sample_t s;
    s.re = re;
    s.im = im;
    samples_to_send = {samples_to_send, s};
    samples_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    repeat (n) queue_sample(pick_value(), pick_value());
  endtask

  // all samples taken, all residues out, pipeline flushed
  task automatic wait_idle();
    int unsigned waited;
    waited = 0;
    do @(negedge clk_i); while (samples_accepted != samples_queued);
    while (predicted_residues.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (predicted_residues.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", predicted_residues.size()));
      predicted_residues.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic start_phase(input mode_e m, input logic [CFG_DATA_W-1:0] spp_v,
                             input logic [CFG_DATA_W-1:0] ppd_v);
    wait_idle();
    write_reg(CFG_MODE, CFG_DATA_W'(m));
    write_reg(CFG_SPP, spp_v);
    write_reg(CFG_PPD, ppd_v);
  endtask

  // stimulus
  initial begin
    int unsigned           phase_no;
    int unsigned           n;
    int unsigned           dwell;
    int unsigned           random_sent;
    int unsigned           roll;
    mode_e                 mode_pick;
    logic [CFG_DATA_W-1:0] spp_pick;
    logic [CFG_DATA_W-1:0] ppd_pick;

    sample_if.valid   = 1'b0;
    sample_if.in_real = '0;
    sample_if.in_imag = '0;
    result_if.ready   = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    rst_ni            = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // three-pulse at full swing on both rails
    start_phase(MODE_THREE_PULSE, 2, 3);
    queue_sample(S_MAX, S_MIN); queue_sample(S_MIN, S_MAX);
    queue_sample(S_MIN, S_MAX); queue_sample(S_MAX, S_MIN);
    queue_sample(S_MAX, S_MIN); queue_sample(S_MIN, S_MAX);

    // two-pulse, zero bins and one pulse act as one and two
    start_phase(MODE_TWO_PULSE, 0, 1);
    queue_sample(S_MAX, S_MIN); queue_sample(S_MIN, S_MAX);

    // three-pulse over a two-pulse dwell gives nothing
    start_phase(MODE_THREE_PULSE, 3, 2);
    queue_random(6);

    // write past the register list restarts the dwell mid pulse
    start_phase(MODE_TWO_PULSE, 2, 4);
    queue_sample(S_MAX, '0); queue_sample('1, S_MIN); queue_sample(S_MIN, S_MAX);
    wait_idle();
    write_reg(CFG_SPARE_IDX, '0);
    queue_random(4);

    // random dwells, mostly whole, some cut short
    phase_no    = 0;
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mode_pick = mode_e'($urandom_range(1));
      roll = $urandom_range(99);
      if (roll < 70) spp_pick = CFG_DATA_W'($urandom_range(6, 1));
      else if (roll < 90) spp_pick = CFG_DATA_W'($urandom_range(40, 7));
      else begin
        case ($urandom_range(2))
          0: spp_pick = '0;
          1: spp_pick = CFG_DATA_W'(MAX_BINS);
          default: spp_pick = '1;
        endcase
      end
      roll = $urandom_range(99);
      if (roll < 75) ppd_pick = CFG_DATA_W'($urandom_range(5, 2));
      else if (roll < 90) ppd_pick = CFG_DATA_W'($urandom_range(12, 6));
      else begin
        case ($urandom_range(3))
          0: ppd_pick = CFG_DATA_W'(0);
          1: ppd_pick = CFG_DATA_W'(1);
          2: ppd_pick = CFG_DATA_W'(MAX_PULSES);
          default: ppd_pick = CFG_DATA_W'(511);
        endcase
      end
      dwell = eff_bins(spp_pick[SPP_W-1:0]) * eff_pulses(ppd_pick[PPD_W-1:0]);
      if ($urandom_range(99) < 80 && dwell <= 160)
        n = dwell * $urandom_range((160 / dwell > 1) ? 160 / dwell : 1, 1);
      else
        n = $urandom_range((dwell > 160) ? 160 : dwell - 1, 1);
      start_phase(mode_pick, spp_pick, ppd_pick);
      send_idle_on = ($urandom_range(3) != 0);
      recv_idle_on = ($urandom_range(3) != 0);
      // once: hold the sender until the block has drained
      if (phase_no == 1) begin
        queue_random(n / 2);
        wait_idle();
        queue_random(n - n / 2);
      end else begin
        queue_random(n);
      end
      random_sent += n;
      phase_no++;
    end

    // longest dwell in pulses, through a pulse count that clamps
    start_phase(MODE_THREE_PULSE, 1, 400);
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    queue_random(MAX_PULSES);

    // bin counts that clamp, first pulse only
    start_phase(MODE_THREE_PULSE, CFG_DATA_W'(MAX_BINS), 3);
    queue_random(32);
    start_phase(MODE_TWO_PULSE, '1, 2);
    queue_random(32);

    // one bin per pulse at full rate, every read after the first forwarded
    start_phase(MODE_THREE_PULSE, 1, 3);
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    queue_random(48);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // run limit
  initial begin
    #(LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
